// ----- design/roj_pkg.sv -----
// Shared types, field widths and codes for the rectangle overlap join.
package roj_pkg;

    localparam int TAG_W        = 16;
    localparam int IDX_PORT_W   = 6;
    localparam int COORD_PORT_W = 32;
    localparam int TOTAL_W      = 32;
    localparam int DIST_W       = 24;
    localparam int THR_W        = DIST_W + 1;
    localparam int BCOUNT_W     = 7;
    localparam int CFG_IDX_W    = 1;

    localparam logic [DIST_W-1:0] DIST_RESET = 24'd2560;

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_PROBE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIST   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BCOUNT = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SWEEP = 4'b0010,
        S_TAIL  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    // token that enters the compare stage with the head cell's entry
    typedef struct packed {
        logic step;
        logic en;
        logic last;
    } cmp_ctl_t;

    // what the compare stage reports for the token it holds
    typedef struct packed {
        logic step;
        logic hit;
        logic last;
    } res_ctl_t;

endpackage

// ----- design/roj_cell.sv -----
// One storage cell of the rotating rectangle row.
module roj_cell #(
    parameter int RW = 128
) (
    input  logic          clk,
    input  logic          shift_en,
    input  logic [RW-1:0] shift_in,
    input  logic          load_en,
    input  logic [RW-1:0] load_data,
    output logic [RW-1:0] rect
);

    logic [RW-1:0] rect_reg;
    logic [RW-1:0] rect_next;

    always_comb
    begin
        rect_next = rect_reg;
        if (load_en)
        begin
            rect_next = load_data;
        end
        else if (shift_en)
        begin
            rect_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rect_reg <= rect_next;
    end

    assign rect = rect_reg;

endmodule

// ----- design/roj_cmp.sv -----
// Two-step compare of the probe against the entry at the head of the row.
module roj_cmp #(
    parameter int C     = 32,
    parameter int IDX_W = 6,
    parameter int DW    = 33
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  roj_pkg::cmp_ctl_t       issue_ctl,
    input  logic [IDX_W-1:0]        issue_idx,
    input  logic signed [C-1:0]     p_xl,
    input  logic signed [C-1:0]     p_yl,
    input  logic signed [C-1:0]     p_xh,
    input  logic signed [C-1:0]     p_yh,
    input  logic signed [DW-1:0]    thr_pos,
    input  logic signed [DW-1:0]    thr_neg,
    input  logic [4*C-1:0]          entry,
    output roj_pkg::res_ctl_t       res,
    output logic [IDX_W-1:0]        res_idx,
    output logic signed [C-1:0]     ov_xl,
    output logic signed [C-1:0]     ov_yl,
    output logic signed [C-1:0]     ov_xh,
    output logic signed [C-1:0]     ov_yh
);

    logic signed [C-1:0]  e_xl;
    logic signed [C-1:0]  e_yl;
    logic signed [C-1:0]  e_xh;
    logic signed [C-1:0]  e_yh;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 near;

    roj_pkg::cmp_ctl_t    ctl_reg;
    logic                 near_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic signed [C-1:0]  xl_reg;
    logic signed [C-1:0]  yl_reg;
    logic signed [C-1:0]  xh_reg;
    logic signed [C-1:0]  yh_reg;

    assign e_xl = entry[C-1:0];
    assign e_yl = entry[2*C-1:C];
    assign e_xh = entry[3*C-1:2*C];
    assign e_yh = entry[4*C-1:3*C];

    assign dx = DW'(p_xl) - DW'(e_xl);
    assign dy = DW'(p_yl) - DW'(e_yl);

    // corner distance strictly inside the threshold on both axes
    assign near = (dx < thr_pos) && (dx > thr_neg) && (dy < thr_pos) && (dy > thr_neg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= issue_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            near_reg <= near && issue_ctl.en;
            idx_reg  <= issue_idx;
            xl_reg   <= (p_xl > e_xl) ? p_xl : e_xl;
            yl_reg   <= (p_yl > e_yl) ? p_yl : e_yl;
            xh_reg   <= (p_xh < e_xh) ? p_xh : e_xh;
            yh_reg   <= (p_yh < e_yh) ? p_yh : e_yh;
        end
    end

    assign res.step = ctl_reg.step;
    assign res.last = ctl_reg.last;
    assign res.hit  = ctl_reg.step && near_reg && (xh_reg > xl_reg) && (yh_reg > yl_reg);
    assign res_idx  = idx_reg;
    assign ov_xl    = xl_reg;
    assign ov_yl    = yl_reg;
    assign ov_xh    = xh_reg;
    assign ov_yh    = yh_reg;

endmodule

// ----- design/rectangle_overlap_join.sv -----
// Top level of the rectangle overlap join: cell row, sequencer and result registers.
//
// Stored rectangles sit in a row of STORE_DEPTH cells. A probe rotates the row one
// place per cycle, while no result waits untaken at the output, past a two-step compare
// unit; the block takes no other request until the probe is through, and the full
// rotation restores the row. Matches leave in ascending entry order, at most one per
// cycle. A match is held in a pending register before it is sent so that the final
// result of a probe can carry last_match; a new request is taken while the final
// result still waits at the output.
module rectangle_overlap_join #(
    parameter int STORE_DEPTH = 64,
    parameter int COORD_BITS  = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [roj_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [roj_pkg::DIST_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             req_type,
    input  logic [roj_pkg::IDX_PORT_W-1:0]         entry_index,
    input  logic [roj_pkg::TAG_W-1:0]              probe_tag,
    input  logic signed [roj_pkg::COORD_PORT_W-1:0] in_x_low,
    input  logic signed [roj_pkg::COORD_PORT_W-1:0] in_y_low,
    input  logic signed [roj_pkg::COORD_PORT_W-1:0] in_x_high,
    input  logic signed [roj_pkg::COORD_PORT_W-1:0] in_y_high,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [roj_pkg::TAG_W-1:0]              out_probe_tag,
    output logic [roj_pkg::IDX_PORT_W-1:0]         match_entry,
    output logic signed [roj_pkg::COORD_PORT_W-1:0] ov_x_low,
    output logic signed [roj_pkg::COORD_PORT_W-1:0] ov_y_low,
    output logic signed [roj_pkg::COORD_PORT_W-1:0] ov_x_high,
    output logic signed [roj_pkg::COORD_PORT_W-1:0] ov_y_high,
    output logic [roj_pkg::TOTAL_W-1:0]            match_total,
    output logic                                   last_match
);

    localparam int C     = COORD_BITS;
    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DW    = (COORD_BITS >= roj_pkg::THR_W) ? COORD_BITS + 1 : roj_pkg::THR_W + 1;
    localparam int RW    = 4 * COORD_BITS;
    localparam int BW    = roj_pkg::BCOUNT_W;
    localparam int PW    = roj_pkg::COORD_PORT_W;
    localparam int XW    = roj_pkg::IDX_PORT_W;
    localparam int TW    = roj_pkg::TOTAL_W;

    roj_pkg::state_t             state_reg;
    roj_pkg::state_t             state_next;
    logic [IDX_W-1:0]            cnt_reg;
    logic [IDX_W-1:0]            cnt_next;
    logic [roj_pkg::DIST_W-1:0]  dist_reg;
    logic [roj_pkg::DIST_W-1:0]  dist_next;
    logic [BW-1:0]               bcount_reg;
    logic [BW-1:0]               bcount_next;
    logic [TW-1:0]               total_reg;
    logic [TW-1:0]               total_next;
    logic [TW-1:0]               total_inc;
    logic                        pend_valid_reg;
    logic                        pend_valid_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    logic [BW-1:0]               lim_reg;
    logic signed [DW-1:0]        thr_pos_reg;
    logic signed [DW-1:0]        thr_neg_reg;
    logic signed [DW-1:0]        thr_ext;
    logic [roj_pkg::TAG_W-1:0]   tag_reg;
    logic signed [C-1:0]         p_xl_reg;
    logic signed [C-1:0]         p_yl_reg;
    logic signed [C-1:0]         p_xh_reg;
    logic signed [C-1:0]         p_yh_reg;

    logic [IDX_W-1:0]            pend_idx_reg;
    logic signed [C-1:0]         pend_xl_reg;
    logic signed [C-1:0]         pend_yl_reg;
    logic signed [C-1:0]         pend_xh_reg;
    logic signed [C-1:0]         pend_yh_reg;
    logic [TW-1:0]               pend_total_reg;

    logic [roj_pkg::TAG_W-1:0]   out_tag_reg;
    logic [IDX_W-1:0]            out_idx_reg;
    logic signed [C-1:0]         out_xl_reg;
    logic signed [C-1:0]         out_yl_reg;
    logic signed [C-1:0]         out_xh_reg;
    logic signed [C-1:0]         out_yh_reg;
    logic [TW-1:0]               out_total_reg;
    logic                        out_last_reg;

    logic                        accept;
    logic                        adv;
    logic                        issue;
    logic                        push_mid;
    logic                        push_last;
    logic [STORE_DEPTH-1:0]      load_en;
    logic [RW-1:0]               load_data;
    logic [RW-1:0]               rect_q [STORE_DEPTH];

    roj_pkg::cmp_ctl_t           issue_ctl;
    roj_pkg::res_ctl_t           res;
    logic [IDX_W-1:0]            res_idx;
    logic signed [C-1:0]         res_xl;
    logic signed [C-1:0]         res_yl;
    logic signed [C-1:0]         res_xh;
    logic signed [C-1:0]         res_yh;

    assign in_ready  = (state_reg == roj_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    // the whole sweep holds while a result waits untaken
    assign adv       = !out_valid_reg || out_ready;
    assign issue     = (state_reg == roj_pkg::S_SWEEP) && adv;
    assign push_mid  = adv && res.hit && pend_valid_reg;
    assign push_last = (state_reg == roj_pkg::S_FLUSH) && pend_valid_reg && adv;
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + 1'b1;
    assign thr_ext   = DW'({dist_reg, 1'b0});

    assign load_data = {in_y_high[C-1:0], in_x_high[C-1:0], in_y_low[C-1:0], in_x_low[C-1:0]};

    // cell row: each cell takes its right neighbor's entry, the first's entry wraps to the last
    for (genvar j = 0; j < STORE_DEPTH; j++)
    begin : g_cell
        localparam int NXT = (j + 1) % STORE_DEPTH;

        assign load_en[j] = accept && (req_type == roj_pkg::REQ_LOAD)
                            && (entry_index == XW'(j));

        roj_cell #(
            .RW(RW)
        ) u_cell (
            .clk      (clk),
            .shift_en (issue),
            .shift_in (rect_q[NXT]),
            .load_en  (load_en[j]),
            .load_data(load_data),
            .rect     (rect_q[j])
        );
    end

    assign issue_ctl.step = (state_reg == roj_pkg::S_SWEEP);
    assign issue_ctl.en   = BW'(cnt_reg) < lim_reg;
    assign issue_ctl.last = (cnt_reg == IDX_W'(STORE_DEPTH - 1));

    roj_cmp #(
        .C    (C),
        .IDX_W(IDX_W),
        .DW   (DW)
    ) u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .issue_ctl(issue_ctl),
        .issue_idx(cnt_reg),
        .p_xl     (p_xl_reg),
        .p_yl     (p_yl_reg),
        .p_xh     (p_xh_reg),
        .p_yh     (p_yh_reg),
        .thr_pos  (thr_pos_reg),
        .thr_neg  (thr_neg_reg),
        .entry    (rect_q[0]),
        .res      (res),
        .res_idx  (res_idx),
        .ov_xl    (res_xl),
        .ov_yl    (res_yl),
        .ov_xh    (res_xh),
        .ov_yh    (res_yh)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        dist_next       = dist_reg;
        bcount_next     = bcount_reg;
        total_next      = total_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cfg_wr_en)
        begin
            if (cfg_index == roj_pkg::REG_DIST)
            begin
                dist_next = cfg_data;
            end
            else if (cfg_index == roj_pkg::REG_BCOUNT)
            begin
                bcount_next = cfg_data[BW-1:0];
            end
        end

        if (push_mid || push_last)
        begin
            out_valid_next = 1'b1;
        end
        if (adv && res.hit)
        begin
            total_next      = total_inc;
            pend_valid_next = 1'b1;
        end
        if (push_last)
        begin
            pend_valid_next = 1'b0;
        end

        unique case (state_reg)
            roj_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        roj_pkg::REQ_PROBE:
                        begin
                            state_next = roj_pkg::S_SWEEP;
                            cnt_next   = '0;
                        end
                        roj_pkg::REQ_CLEAR:
                        begin
                            total_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            roj_pkg::S_SWEEP:
            begin
                if (adv)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (issue_ctl.last)
                    begin
                        state_next = roj_pkg::S_TAIL;
                    end
                end
            end
            roj_pkg::S_TAIL:
            begin
                // the final token is judged on this advance
                if (adv)
                begin
                    state_next = roj_pkg::S_FLUSH;
                end
            end
            roj_pkg::S_FLUSH:
            begin
                if (!pend_valid_reg || adv)
                begin
                    state_next = roj_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = roj_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= roj_pkg::S_IDLE;
            cnt_reg        <= '0;
            dist_reg       <= roj_pkg::DIST_RESET;
            bcount_reg     <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            dist_reg       <= dist_next;
            bcount_reg     <= bcount_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req_type == roj_pkg::REQ_PROBE))
        begin
            tag_reg     <= probe_tag;
            p_xl_reg    <= in_x_low[C-1:0];
            p_yl_reg    <= in_y_low[C-1:0];
            p_xh_reg    <= in_x_high[C-1:0];
            p_yh_reg    <= in_y_high[C-1:0];
            lim_reg     <= (bcount_reg > BW'(STORE_DEPTH)) ? BW'(STORE_DEPTH) : bcount_reg;
            thr_pos_reg <= thr_ext;
            thr_neg_reg <= -thr_ext;
        end

        // hold each match until the next match or the flush shows whether it is the probe's last
        if (adv && res.hit)
        begin
            pend_idx_reg   <= res_idx;
            pend_xl_reg    <= res_xl;
            pend_yl_reg    <= res_yl;
            pend_xh_reg    <= res_xh;
            pend_yh_reg    <= res_yh;
            pend_total_reg <= total_inc;
        end

        if (push_mid || push_last)
        begin
            out_tag_reg   <= tag_reg;
            out_idx_reg   <= pend_idx_reg;
            out_xl_reg    <= pend_xl_reg;
            out_yl_reg    <= pend_yl_reg;
            out_xh_reg    <= pend_xh_reg;
            out_yh_reg    <= pend_yh_reg;
            out_total_reg <= pend_total_reg;
            out_last_reg  <= push_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_probe_tag = out_tag_reg;
    assign match_entry   = XW'(out_idx_reg);
    assign ov_x_low      = PW'(out_xl_reg);
    assign ov_y_low      = PW'(out_yl_reg);
    assign ov_x_high     = PW'(out_xh_reg);
    assign ov_y_high     = PW'(out_yh_reg);
    assign match_total   = out_total_reg;
    assign last_match    = out_last_reg;

endmodule

// ----- dv/rectangle_overlap_join_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rectangle_overlap_join: directed table, store fill, then random request phases.
module rectangle_overlap_join_tb;

    localparam int COORD_PORT_W   = roj_pkg::COORD_PORT_W;
    localparam int IDX_PORT_W     = roj_pkg::IDX_PORT_W;
    localparam int TAG_W          = roj_pkg::TAG_W;
    localparam int TOTAL_W        = roj_pkg::TOTAL_W;
    localparam int CFG_IDX_W      = roj_pkg::CFG_IDX_W;
    localparam int DIST_W         = roj_pkg::DIST_W;
    localparam int BCOUNT_W       = roj_pkg::BCOUNT_W;

    localparam int DEPTH          = 64;
    localparam int SETTLE_CYCLES  = DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 330;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [COORD_PORT_W-1:0] xl;
        logic signed [COORD_PORT_W-1:0] yl;
        logic signed [COORD_PORT_W-1:0] xh;
        logic signed [COORD_PORT_W-1:0] yh;
    } box_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [IDX_PORT_W-1:0] idx;
        logic [TAG_W-1:0]      tag;
        box_t                  b;
    } request_t;

    typedef struct packed {
        logic [TAG_W-1:0]      tag;
        logic [IDX_PORT_W-1:0] entry;
        box_t                  ov;
        logic [TOTAL_W-1:0]    total;
        logic                  last;
    } match_t;

    typedef enum bit {ROW_WRITE, ROW_REQUEST} row_kind_t;

    typedef struct {
        row_kind_t             act;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [DIST_W-1:0]     reg_val;
        request_t              rq;
        bit                    typed;
        match_t                want;
    } plan_row_t;

    typedef longint quad_t [4];

    localparam box_t ENTRY_A    = '{32'sh0, 32'sh0, 32'sh10000, 32'sh10000};
    localparam box_t ENTRY_B    = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    localparam box_t PROBE_NEAR = '{32'sh100, 32'sh200, 32'sh20000, 32'sh8000};
    localparam box_t NEAR_OV    = '{32'sh100, 32'sh200, 32'sh10000, 32'sh8000};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [CFG_IDX_W-1:0]           cfg_index;
    logic [DIST_W-1:0]              cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [1:0]                     req_type;
    logic [IDX_PORT_W-1:0]          entry_index;
    logic [TAG_W-1:0]               probe_tag;
    logic signed [COORD_PORT_W-1:0] in_x_low;
    logic signed [COORD_PORT_W-1:0] in_y_low;
    logic signed [COORD_PORT_W-1:0] in_x_high;
    logic signed [COORD_PORT_W-1:0] in_y_high;
    logic                           out_valid;
    logic                           out_ready;
    logic [TAG_W-1:0]               out_probe_tag;
    logic [IDX_PORT_W-1:0]          match_entry;
    logic signed [COORD_PORT_W-1:0] ov_x_low;
    logic signed [COORD_PORT_W-1:0] ov_y_low;
    logic signed [COORD_PORT_W-1:0] ov_x_high;
    logic signed [COORD_PORT_W-1:0] ov_y_high;
    logic [TOTAL_W-1:0]             match_total;
    logic                           last_match;

    // join state as the block should hold it
    quad_t                stored [DEPTH];
    logic [TOTAL_W-1:0]   tally;
    logic [DIST_W-1:0]    half_side;
    logic [BCOUNT_W-1:0]  probe_span;

    match_t     fresh[$];
    match_t     pending_matches[$];
    plan_row_t  plan[$];
    int         mismatches = 0;
    int         accepted_items = 0;
    bit         no_idle = 1'b0;

    rectangle_overlap_join uut (.*);

    always #6 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    function automatic void corners(input box_t b, output quad_t c);
        c[0] = $signed(b.xl);
        c[1] = $signed(b.yl);
        c[2] = $signed(b.xh);
        c[3] = $signed(b.yh);
    endfunction

    function automatic longint span_between(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Apply one request to the join state; matches land in fresh.
    function automatic void join_request(input request_t rq);
        quad_t  p;
        quad_t  o;
        longint thr;
        int     lim;
        match_t m;
        fresh.delete();
        corners(rq.b, p);
        if (rq.kind == roj_pkg::REQ_LOAD)
            stored[rq.idx] = p;
        else if (rq.kind == roj_pkg::REQ_CLEAR)
            tally = '0;
        else if (rq.kind == roj_pkg::REQ_PROBE)
        begin
            lim = (probe_span > DEPTH) ? DEPTH : int'(probe_span);
            thr = 2 * longint'(half_side);
            for (int j = 0; j < lim; j++)
            begin
                if (span_between(p[0], stored[j][0]) < thr &&
                    span_between(p[1], stored[j][1]) < thr)
                begin
                    // lows take the larger edge, highs the smaller
                    for (int k = 0; k < 4; k++)
                        o[k] = ((p[k] > stored[j][k]) == (k < 2)) ? p[k] : stored[j][k];
                    if (o[2] > o[0] && o[3] > o[1])
                    begin
                        if (tally != '1)
                            tally++;
                        m.tag   = rq.tag;
                        m.entry = IDX_PORT_W'(j);
                        m.ov.xl = o[0][31:0];
                        m.ov.yl = o[1][31:0];
                        m.ov.xh = o[2][31:0];
                        m.ov.yh = o[3][31:0];
                        m.total = tally;
                        m.last  = 1'b0;
                        fresh.insert(fresh.size(), m);
                    end
                end
            end
            if (fresh.size() != 0)
                fresh[fresh.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void plan_req(input logic [1:0] kind, input logic [IDX_PORT_W-1:0] idx,
                                     input logic [TAG_W-1:0] tag, input box_t b);
        plan_row_t row;
        row.act     = ROW_REQUEST;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.rq      = '{kind, idx, tag, b};
        row.typed   = 1'b0;
        row.want    = '0;
        plan.insert(plan.size(), row);
    endfunction

    // probe whose single, final match is typed in
    function automatic void plan_hit(input logic [TAG_W-1:0] tag, input box_t b,
                                     input logic [IDX_PORT_W-1:0] entry, input box_t ov,
                                     input logic [TOTAL_W-1:0] total);
        plan_req(roj_pkg::REQ_PROBE, '0, tag, b);
        plan[plan.size() - 1].typed = 1'b1;
        plan[plan.size() - 1].want  = '{tag, entry, ov, total, 1'b1};
    endfunction

    function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [DIST_W-1:0] val);
        plan_row_t row;
        row.act     = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        row.rq      = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        plan.insert(plan.size(), row);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic box_t cluster_box();
        box_t b;
        int   x0;
        int   y0;
        x0   = int'($urandom_range(0, 32'h4000)) - 32'sh2000;
        y0   = int'($urandom_range(0, 32'h4000)) - 32'sh2000;
        b.xl = x0;
        b.yl = y0;
        // widths may come out zero or negative
        b.xh = x0 + int'($urandom_range(0, 32'h8000)) - 32'sh100;
        b.yh = y0 + int'($urandom_range(0, 32'h8000)) - 32'sh100;
        return b;
    endfunction

    task automatic send_request(input request_t rq, input bit typed, input match_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rq.kind;
        entry_index <= rq.idx;
        probe_tag   <= rq.tag;
        in_x_low    <= rq.b.xl;
        in_y_low    <= rq.b.yl;
        in_x_high   <= rq.b.xh;
        in_y_high   <= rq.b.yh;
        do @(posedge clk); while (!in_ready);
        join_request(rq);
        if (typed)
            pending_matches.insert(pending_matches.size(), want);
        else
            foreach (fresh[i])
                pending_matches.insert(pending_matches.size(), fresh[i]);
        if (rq.kind != REQ_UNUSED)
            accepted_items++;
    endtask

    // Drop valid, drain all matches, then let a silent sweep finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == roj_pkg::REG_DIST)
            half_side = val;
        else
            probe_span = val[BCOUNT_W-1:0];
    endtask

    task automatic run_phase();
        request_t rq;
        int       steps;
        int       pick;
        settle();
        case ($urandom_range(0, 5))
            0:       write_reg(roj_pkg::REG_DIST, '0);
            1:       write_reg(roj_pkg::REG_DIST, '1);
            2:       write_reg(roj_pkg::REG_DIST, roj_pkg::DIST_RESET);
            default: write_reg(roj_pkg::REG_DIST, DIST_W'($urandom_range(16, 32'h3000)));
        endcase
        case ($urandom_range(0, 5))
            0:       write_reg(roj_pkg::REG_BCOUNT, '0);
            1:       write_reg(roj_pkg::REG_BCOUNT, DIST_W'(DEPTH));
            2:       write_reg(roj_pkg::REG_BCOUNT, DIST_W'(127));    // past the store: clamps
            3:       write_reg(roj_pkg::REG_BCOUNT, DIST_W'(1));
            default: write_reg(roj_pkg::REG_BCOUNT, DIST_W'($urandom_range(2, DEPTH - 1)));
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
        steps = $urandom_range(4, 14);
        repeat (steps)
        begin
            pick   = $urandom_range(0, 99);
            rq.tag = TAG_W'($urandom);
            rq.idx = IDX_PORT_W'($urandom);
            rq.b   = cluster_box();
            if (pick < 55)
                rq.kind = roj_pkg::REQ_PROBE;
            else if (pick < 85)
                rq.kind = roj_pkg::REQ_LOAD;
            else if (pick < 90)
                rq.kind = roj_pkg::REQ_CLEAR;
            else if (pick < 94)
                rq.kind = REQ_UNUSED;
            else
            begin
                rq.kind = (pick < 97) ? roj_pkg::REQ_PROBE : roj_pkg::REQ_LOAD;
                rq.b    = '{$urandom, $urandom, $urandom, $urandom};
            end
            send_request(rq, 1'b0, '0);
        end
        no_idle = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v, input match_t want);
        if (got_v !== want_v)
            report_mismatch($sformatf("tag %h entry %0d: %s got %h, want %h",
                                      want.tag, want.entry, name, got_v, want_v));
    endtask

    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.tag   = out_probe_tag;
            got.entry = match_entry;
            got.ov.xl = ov_x_low;
            got.ov.yl = ov_y_low;
            got.ov.xh = ov_x_high;
            got.ov.yh = ov_y_high;
            got.total = match_total;
            got.last  = last_match;
            if (pending_matches.size() == 0)
                report_mismatch($sformatf("unexpected match tag %h entry %0d",
                                          got.tag, got.entry));
            else
            begin
                want = pending_matches.pop_front();
                check_field("out_probe_tag", 32'(got.tag), 32'(want.tag), want);
                check_field("match_entry", 32'(got.entry), 32'(want.entry), want);
                check_field("ov_x_low", 32'(got.ov.xl), 32'(want.ov.xl), want);
                check_field("ov_y_low", 32'(got.ov.yl), 32'(want.ov.yl), want);
                check_field("ov_x_high", 32'(got.ov.xh), 32'(want.ov.xh), want);
                check_field("ov_y_high", 32'(got.ov.yh), 32'(want.ov.yh), want);
                check_field("match_total", 32'(got.total), 32'(want.total), want);
                check_field("last_match", 32'(got.last), 32'(want.last), want);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        request_t rq;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        req_type    = roj_pkg::REQ_LOAD;
        entry_index = '0;
        probe_tag   = '0;
        in_x_low    = '0;
        in_y_low    = '0;
        in_x_high   = '0;
        in_y_high   = '0;
        tally       = '0;
        half_side   = roj_pkg::DIST_RESET;
        probe_span  = '0;

        // nothing compared after reset
        plan_req(roj_pkg::REQ_PROBE, '0, 16'hFFFF, '{32'sh0, 32'sh0, 32'sh1000, 32'sh1000});
        plan_req(roj_pkg::REQ_LOAD, 6'd0, 16'h0, ENTRY_A);
        plan_write(roj_pkg::REG_BCOUNT, 24'd1);
        plan_hit(16'h0001, PROBE_NEAR, 6'd0, NEAR_OV, 32'd1);
        // corner gap one below and exactly at twice the half side
        plan_hit(16'h0002, '{32'sh13FF, 32'sh0, 32'sh20000, 32'sh20000}, 6'd0,
                 '{32'sh13FF, 32'sh0, 32'sh10000, 32'sh10000}, 32'd2);
        plan_req(roj_pkg::REQ_PROBE, '0, 16'h0003,
                 '{32'sh1400, 32'sh0, 32'sh20000, 32'sh20000});
        plan_hit(16'h0004, '{32'sh0, -32'sh13FF, 32'sh20000, 32'sh20000}, 6'd0, ENTRY_A, 32'd3);
        // zero-width overlap
        plan_req(roj_pkg::REQ_PROBE, '0, 16'h0005, '{32'sh10, 32'sh10, 32'sh10, 32'sh20000});
        plan_req(roj_pkg::REQ_CLEAR, '0, 16'h0, '0);
        plan_hit(16'h0006, PROBE_NEAR, 6'd0, NEAR_OV, 32'd1);
        plan_req(REQ_UNUSED, 6'd63, 16'hAAAA,
                 '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF});
        plan_req(roj_pkg::REQ_LOAD, 6'd1, 16'h0, ENTRY_B);
        plan_write(roj_pkg::REG_BCOUNT, 24'd2);
        plan_write(roj_pkg::REG_DIST, 24'hFFFFFF);
        plan_req(roj_pkg::REQ_PROBE, '0, 16'h0007, PROBE_NEAR);
        plan_hit(16'h0008, '{32'sh80000001, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 6'd1,
                 '{32'sh80000001, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 32'd3);
        plan_write(roj_pkg::REG_DIST, 24'd0);
        plan_req(roj_pkg::REQ_PROBE, '0, 16'h0009, ENTRY_B);
        plan_write(roj_pkg::REG_DIST, roj_pkg::DIST_RESET);
        plan_req(roj_pkg::REQ_PROBE, '0, 16'h0000, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].act == ROW_WRITE)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_request(plan[i].rq, plan[i].typed, plan[i].want);
        end

        // fill the whole store so that any count is legal from here on
        for (int e = 0; e < DEPTH; e++)
        begin
            rq.kind = roj_pkg::REQ_LOAD;
            rq.idx  = IDX_PORT_W'(e);
            rq.tag  = TAG_W'($urandom);
            rq.b    = cluster_box();
            send_request(rq, 1'b0, '0);
        end

        while (accepted_items < ITEM_TARGET)
            run_phase();

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/roj_pkg.sv
design/roj_cell.sv
design/roj_cmp.sv
design/rectangle_overlap_join.sv
dv/rectangle_overlap_join_tb.sv
